>>> rtl/clp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clp_pkg: shared definitions for the waveshaping clipper
// Widths, register codes, shaper constants and beat types for all stages.
// ----------------------------------------------------------------------------
package clp_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int ATAN_STEPS  = 16;
  localparam int FRAC        = SAMPLE_BITS - 1;

  localparam int CORDIC_ITERS  = (ATAN_STEPS > 24) ? 24 : ATAN_STEPS;
  localparam int CORDIC_STAGES = (CORDIC_ITERS + 1) / 2;

  // register file
  localparam int GAIN_W     = 16;
  localparam int CINV_W     = 24;
  localparam int CEIL_W     = 16;
  localparam int MODE_W     = 2;
  localparam int SOFT_W     = 13;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CEIL_INV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFTNESS  = 3'd5;

  localparam logic [MODE_W-1:0] MODE_HARD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUINTIC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ATAN    = 2'd2;

  // datapath widths
  localparam int M1_W    = SAMPLE_BITS + GAIN_W + 1;
  localparam int G_W     = SAMPLE_BITS + 5;
  localparam int M2_W    = G_W + CINV_W + 1;
  localparam int S_W     = 44;            // scaled sample, Q.30
  localparam int QS_W    = 32;            // in-range quintic input
  localparam int QP_W    = 33;            // quintic partial powers
  localparam int QPROD_W = QP_W + QS_W;
  localparam int COEF_W  = 28;
  localparam int QC_W    = COEF_W + QP_W;
  localparam int Y_W     = 34;            // shaped value, Q.30
  localparam int K_W     = 13;            // arctan slope, Q.12
  localparam int KP_W    = S_W + K_W + 1;
  localparam int C_W     = 48;            // CORDIC x/y
  localparam int Z_W     = 32;            // CORDIC angle
  localparam int OP_W    = Y_W + CEIL_W + 1;

  localparam int QUIN_LAT  = 6;
  localparam int SHAPE_LAT = 2 + CORDIC_STAGES;
  localparam int HQ_N      = SHAPE_LAT - QUIN_LAT + 1;

  localparam logic signed [S_W-1:0]    S_ONE      = S_W'(64'sd1 <<< 30);
  localparam logic signed [S_W-1:0]    QUIN_LIM   = S_W'(64'sd5 <<< 28);
  localparam logic signed [COEF_W-1:0] QUIN_COEF  = COEF_W'(87960930);
  localparam logic signed [Y_W-1:0]    Y_ONE      = Y_W'(64'sd1 <<< 30);
  localparam logic signed [C_W-1:0]    CORDIC_X0  = C_W'(64'sd1 <<< 30);

  typedef struct packed {
    logic                    bypass;
    logic [GAIN_W-1:0]       band_gain;
    logic [CINV_W-1:0]       ceiling_inverse;
    logic [CEIL_W-1:0]       ceiling;
    logic [MODE_W-1:0]       wave_mode;
    logic [SOFT_W-1:0]       softness;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic signed [S_W-1:0]   s;
    logic [SAMPLE_BITS-1:0]  raw;
  } scaled_beat_t;

  typedef struct packed {
    logic                    valid;
    logic signed [Y_W-1:0]   y;
    logic [SAMPLE_BITS-1:0]  raw;
  } shaped_beat_t;

  typedef struct packed {
    logic                    valid;
    logic [SAMPLE_BITS-1:0]  sample;
  } out_beat_t;

  // atan(2^-i), 2^30 per quarter turn
  function automatic logic signed [Z_W-1:0] atan_angle(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:  a = 32'sd536870912;
      1:  a = 32'sd316933406;
      2:  a = 32'sd167458907;
      3:  a = 32'sd85004756;
      4:  a = 32'sd42667331;
      5:  a = 32'sd21354465;
      6:  a = 32'sd10679838;
      7:  a = 32'sd5340245;
      8:  a = 32'sd2670163;
      9:  a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      16: a = 32'sd10430;
      17: a = 32'sd5215;
      18: a = 32'sd2608;
      19: a = 32'sd1304;
      20: a = 32'sd652;
      21: a = 32'sd326;
      22: a = 32'sd163;
      default: a = 32'sd81;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> rtl/audio_waveshaping_clipper_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_waveshaping_clipper_top: audio waveshaping clipper
// Gain, inverse ceiling, hard/quintic/arctangent shaper, ceiling, saturate.
// ----------------------------------------------------------------------------
// Takes one Q1.23 sample per clock and returns one per clock unless out_ready
// stalls fill the skid and drop in_ready. A sample passes 3 scaling stages,
// 2 + 8 shaper stages set by the 16-step CORDIC at two steps per stage,
// 2 output stages and the output register, the first of these loading at
// the accepting edge; out_valid offers it from the output register.
// The output register has a one-beat skid, so in_ready drops only when two
// finished results are waiting. Configuration is written through
// cfg_we/cfg_index/cfg_wdata and must only change while the pipeline is empty.
// ----------------------------------------------------------------------------
module audio_waveshaping_clipper_top (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic signed [clp_pkg::SAMPLE_BITS-1:0]    in_sample_in,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic signed [clp_pkg::SAMPLE_BITS-1:0]         out_sample_out,
  input  wire logic                                      cfg_we,
  input  wire logic [clp_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  wire logic [clp_pkg::CFG_DATA_W-1:0]            cfg_wdata
);

  clp_pkg::cfg_t          cfg_r;
  clp_pkg::scaled_beat_t  scaled;
  clp_pkg::shaped_beat_t  shaped;
  clp_pkg::out_beat_t     result;
  logic                   en;
  logic [clp_pkg::SAMPLE_BITS-1:0] out_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bypass          <= 1'b0;
      cfg_r.band_gain       <= 16'd4096;
      cfg_r.ceiling_inverse <= 24'd65536;
      cfg_r.ceiling         <= 16'd4096;
      cfg_r.wave_mode       <= clp_pkg::MODE_HARD;
      cfg_r.softness        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        clp_pkg::CFG_BYPASS:    cfg_r.bypass          <= cfg_wdata[0];
        clp_pkg::CFG_BAND_GAIN: cfg_r.band_gain       <= cfg_wdata[15:0];
        clp_pkg::CFG_CEIL_INV:  cfg_r.ceiling_inverse <= cfg_wdata[23:0];
        clp_pkg::CFG_CEILING:   cfg_r.ceiling         <= cfg_wdata[15:0];
        clp_pkg::CFG_WAVE_MODE: cfg_r.wave_mode       <= cfg_wdata[1:0];
        clp_pkg::CFG_SOFTNESS:  cfg_r.softness        <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  assign in_ready = en;

  clp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_sample (in_sample_in),
    .cfg       (cfg_r),
    .dout      (scaled)
  );

  clp_shaper u_shaper (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg_r),
    .din   (scaled),
    .dout  (shaped)
  );

  clp_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg_r),
    .din   (shaped),
    .dout  (result)
  );

  clp_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .din        (result),
    .ready      (en),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample)
  );

  assign out_sample_out = $signed(out_sample);

endmodule
`default_nettype wire

>>> rtl/clp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clp_front: input scaling
// Band gain then inverse ceiling, three registered stages, result in Q.30.
// ----------------------------------------------------------------------------
module clp_front (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       en,
  input  wire logic                                       in_valid,
  input  wire logic signed [clp_pkg::SAMPLE_BITS-1:0]     in_sample,
  input  wire clp_pkg::cfg_t                              cfg,
  output clp_pkg::scaled_beat_t                           dout
);

  logic [2:0]                               v_r;
  logic [clp_pkg::SAMPLE_BITS-1:0]          raw1_r, raw2_r, raw3_r;
  logic signed [clp_pkg::M1_W-1:0]          m1_r;
  logic signed [clp_pkg::M2_W-1:0]          m2_r;
  logic signed [clp_pkg::S_W-1:0]           s_r;
  logic signed [clp_pkg::M1_W-1:0]          m1_rnd;
  logic signed [clp_pkg::M2_W-1:0]          m2_rnd;
  logic signed [clp_pkg::G_W-1:0]           g;

  always_comb begin
    m1_rnd = m1_r + (clp_pkg::M1_W'(1) <<< 11);
    g      = clp_pkg::G_W'(m1_rnd >>> 12);
    m2_rnd = m2_r + (clp_pkg::M2_W'(1) <<< (clp_pkg::FRAC - 15));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw1_r <= in_sample;
      raw2_r <= raw1_r;
      raw3_r <= raw2_r;
      m1_r   <= clp_pkg::M1_W'(in_sample)
              * clp_pkg::M1_W'($signed({1'b0, cfg.band_gain}));
      m2_r   <= clp_pkg::M2_W'(g)
              * clp_pkg::M2_W'($signed({1'b0, cfg.ceiling_inverse}));
      s_r    <= clp_pkg::S_W'(m2_rnd >>> (clp_pkg::FRAC - 14));
    end
  end

  assign dout.valid = v_r[2];
  assign dout.s     = s_r;
  assign dout.raw   = raw3_r;

endmodule
`default_nettype wire

>>> rtl/clp_shaper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clp_shaper: waveshaper
// Hard clamp, quintic and CORDIC arctangent run side by side; the hard and
// quintic results are delayed to line up with the CORDIC and one is picked.
// ----------------------------------------------------------------------------
module clp_shaper (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire clp_pkg::cfg_t         cfg,
  input  wire clp_pkg::scaled_beat_t din,
  output clp_pkg::shaped_beat_t      dout
);

  logic [clp_pkg::SHAPE_LAT-1:0]            v_r;
  logic [clp_pkg::SAMPLE_BITS-1:0]          raw_r [clp_pkg::SHAPE_LAT];

  // slope k = 6554 - round(0.6 * softness), softness saturated to one
  logic [clp_pkg::SOFT_W-1:0]               soft_sat;
  logic [24:0]                              kprod;
  logic [clp_pkg::K_W-1:0]                  k_nxt, k_r;

  always_comb begin
    soft_sat = (cfg.softness > 13'd4096) ? 13'd4096 : cfg.softness;
    kprod    = 25'(soft_sat) * 25'd2458 + 25'd2048;
    k_nxt    = 13'd6554 - 13'(kprod >> 12);
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[clp_pkg::SHAPE_LAT-2:0], din.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw_r[0] <= din.raw;
      for (int i = 1; i < clp_pkg::SHAPE_LAT; i++) raw_r[i] <= raw_r[i-1];
    end
  end

  // ---------------- hard clamp and quintic ----------------
  logic signed [clp_pkg::QS_W-1:0]    qs_r   [5];
  logic                               qin_r  [5];
  logic                               qneg_r [5];
  logic signed [clp_pkg::Y_W-1:0]     hard_r [5];
  logic signed [clp_pkg::QPROD_W-1:0] qprod_r [4];
  logic signed [clp_pkg::QC_W-1:0]    cprod_r;
  logic signed [clp_pkg::QP_W-1:0]    qp [4];
  logic signed [clp_pkg::Y_W-1:0]     hard_nxt, yq, hq_nxt;
  logic signed [clp_pkg::Y_W-1:0]     hq_r [clp_pkg::HQ_N];
  logic signed [clp_pkg::QS_W-1:0]    s32;

  always_comb begin
    s32 = clp_pkg::QS_W'(din.s);
    if (din.s > clp_pkg::S_ONE) begin
      hard_nxt = clp_pkg::Y_ONE;
    end else if (din.s < -clp_pkg::S_ONE) begin
      hard_nxt = -clp_pkg::Y_ONE;
    end else begin
      hard_nxt = clp_pkg::Y_W'(din.s);
    end
    for (int i = 0; i < 4; i++) begin
      qp[i] = clp_pkg::QP_W'((qprod_r[i] + (clp_pkg::QPROD_W'(1) <<< 29)) >>> 30);
    end
    yq = clp_pkg::Y_W'(qs_r[4])
       - clp_pkg::Y_W'((cprod_r + (clp_pkg::QC_W'(1) <<< 29)) >>> 30);
    case (cfg.wave_mode)
      clp_pkg::MODE_HARD:    hq_nxt = hard_r[4];
      clp_pkg::MODE_QUINTIC: begin
        if (qin_r[4]) hq_nxt = yq;
        else          hq_nxt = qneg_r[4] ? -clp_pkg::Y_ONE : clp_pkg::Y_ONE;
      end
      default:               hq_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qs_r[0]   <= s32;
      qin_r[0]  <= (din.s > -clp_pkg::QUIN_LIM) && (din.s < clp_pkg::QUIN_LIM);
      qneg_r[0] <= din.s[clp_pkg::S_W-1];
      hard_r[0] <= hard_nxt;
      for (int i = 1; i < 5; i++) begin
        qs_r[i]   <= qs_r[i-1];
        qin_r[i]  <= qin_r[i-1];
        qneg_r[i] <= qneg_r[i-1];
        hard_r[i] <= hard_r[i-1];
      end
      qprod_r[0] <= clp_pkg::QPROD_W'(s32) * clp_pkg::QPROD_W'(s32);
      for (int i = 1; i < 4; i++) begin
        qprod_r[i] <= clp_pkg::QPROD_W'(qp[i-1]) * clp_pkg::QPROD_W'(qs_r[i-1]);
      end
      cprod_r  <= clp_pkg::QC_W'(qp[3]) * clp_pkg::QC_W'(clp_pkg::QUIN_COEF);
      hq_r[0]  <= hq_nxt;
      for (int i = 1; i < clp_pkg::HQ_N; i++) hq_r[i] <= hq_r[i-1];
    end
  end

  // ---------------- arctangent, vectoring CORDIC ----------------
  logic signed [clp_pkg::KP_W-1:0] kp_r;
  logic signed [clp_pkg::C_W-1:0]  cx_r [clp_pkg::CORDIC_STAGES+1];
  logic signed [clp_pkg::C_W-1:0]  cy_r [clp_pkg::CORDIC_STAGES+1];
  logic signed [clp_pkg::Z_W-1:0]  cz_r [clp_pkg::CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      kp_r    <= clp_pkg::KP_W'(din.s) * clp_pkg::KP_W'($signed({1'b0, k_r}));
      cx_r[0] <= clp_pkg::CORDIC_X0;
      cy_r[0] <= clp_pkg::C_W'((kp_r + (clp_pkg::KP_W'(1) <<< 11)) >>> 12);
      cz_r[0] <= '0;
    end
  end

  // two iterations per stage
  for (genvar j = 0; j < clp_pkg::CORDIC_STAGES; j++) begin : g_cordic
    logic signed [clp_pkg::C_W-1:0] xt, yt, xs, ys;
    logic signed [clp_pkg::Z_W-1:0] zt;

    always_comb begin
      xt = cx_r[j];
      yt = cy_r[j];
      zt = cz_r[j];
      xs = '0;
      ys = '0;
      for (int t = 0; t < 2; t++) begin
        if (2 * j + t < clp_pkg::CORDIC_ITERS) begin
          xs = xt >>> (2 * j + t);
          ys = yt >>> (2 * j + t);
          if (yt > 0) begin
            xt = xt + ys;
            yt = yt - xs;
            zt = zt + clp_pkg::atan_angle(2 * j + t);
          end else begin
            xt = xt - ys;
            yt = yt + xs;
            zt = zt - clp_pkg::atan_angle(2 * j + t);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[j+1] <= xt;
        cy_r[j+1] <= yt;
        cz_r[j+1] <= zt;
      end
    end
  end

  always_comb begin
    dout.valid = v_r[clp_pkg::SHAPE_LAT-1];
    dout.raw   = raw_r[clp_pkg::SHAPE_LAT-1];
    if (cfg.wave_mode == clp_pkg::MODE_ATAN) begin
      dout.y = clp_pkg::Y_W'(cz_r[clp_pkg::CORDIC_STAGES]);
    end else begin
      dout.y = hq_r[clp_pkg::HQ_N-1];
    end
  end

endmodule
`default_nettype wire

>>> rtl/clp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clp_back: output scaling
// Multiply by the ceiling, round, saturate to the sample width, bypass mux.
// ----------------------------------------------------------------------------
module clp_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire clp_pkg::cfg_t         cfg,
  input  wire clp_pkg::shaped_beat_t din,
  output clp_pkg::out_beat_t         dout
);

  localparam logic signed [clp_pkg::OP_W-1:0] SAT_HI =
    (clp_pkg::OP_W'(1) <<< clp_pkg::FRAC) - clp_pkg::OP_W'(1);
  localparam logic signed [clp_pkg::OP_W-1:0] SAT_LO =
    -(clp_pkg::OP_W'(1) <<< clp_pkg::FRAC);

  logic [1:0]                          v_r;
  logic signed [clp_pkg::OP_W-1:0]     prod_r;
  logic [clp_pkg::SAMPLE_BITS-1:0]     raw_r;
  logic [clp_pkg::SAMPLE_BITS-1:0]     out_r, out_nxt;
  logic signed [clp_pkg::OP_W-1:0]     r;

  always_comb begin
    r = (prod_r + (clp_pkg::OP_W'(1) <<< (41 - clp_pkg::FRAC))) >>> (42 - clp_pkg::FRAC);
    if (cfg.bypass)        out_nxt = raw_r;
    else if (r > SAT_HI)   out_nxt = clp_pkg::SAMPLE_BITS'(SAT_HI);
    else if (r < SAT_LO)   out_nxt = clp_pkg::SAMPLE_BITS'(SAT_LO);
    else                   out_nxt = clp_pkg::SAMPLE_BITS'(r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], din.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= clp_pkg::OP_W'(din.y) * clp_pkg::OP_W'($signed({1'b0, cfg.ceiling}));
      raw_r  <= din.raw;
      out_r  <= out_nxt;
    end
  end

  assign dout.valid  = v_r[1];
  assign dout.sample = out_r;

endmodule
`default_nettype wire

>>> rtl/clp_outbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clp_outbuf: output register with skid entry
// Holds a waiting beat while the pipeline delivers one more; pipeline runs
// whenever the skid entry is free.
// ----------------------------------------------------------------------------
module clp_outbuf (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire clp_pkg::out_beat_t                  din,
  output logic                                     ready,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [clp_pkg::SAMPLE_BITS-1:0]          out_sample
);

  logic                              main_v_r, skid_v_r;
  logic [clp_pkg::SAMPLE_BITS-1:0]   main_d_r, skid_d_r;
  logic                              push, pop;

  assign ready = !skid_v_r;
  assign push  = din.valid && !skid_v_r;
  assign pop   = main_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop && skid_v_r) begin
        skid_v_r <= 1'b0;
      end else if (push && (pop || !main_v_r)) begin
        main_v_r <= 1'b1;
      end else if (push) begin
        skid_v_r <= 1'b1;
      end else if (pop) begin
        main_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_v_r) begin
      main_d_r <= skid_d_r;
    end else if (push && (pop || !main_v_r)) begin
      main_d_r <= din.sample;
    end
    if (push && main_v_r && !pop) begin
      skid_d_r <= din.sample;
    end
  end

  assign out_valid  = main_v_r;
  assign out_sample = main_d_r;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry holds a beat while output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(main_v_r && !out_ready))
    else $error("skid entry filled without an output stall");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_ready) |=> (main_v_r && !skid_v_r))
    else $error("skid entry not moved to output register on pop");

endmodule
`default_nettype wire

>>> bench/clipper_checker.sv
// ----------------------------------------------------------------------------
// clipper_checker: scoreboard for the waveshaping clipper
// Watches accepted input beats and config writes, predicts each clipped
// sample in fixed point, and compares every output beat in order.
// ----------------------------------------------------------------------------
module clipper_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_ready,
  input  wire logic [clp_pkg::SAMPLE_BITS-1:0]      in_sample_in,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_ready,
  input  wire logic [clp_pkg::SAMPLE_BITS-1:0]      out_sample_out,
  input  wire logic                                 cfg_we,
  input  wire logic [clp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [clp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output int                                        errors,
  output int                                        pending
);

  logic                          bypass_q;
  logic [clp_pkg::GAIN_W-1:0]    gain_q;
  logic [clp_pkg::CINV_W-1:0]    cinv_q;
  logic [clp_pkg::CEIL_W-1:0]    ceil_q;
  logic [clp_pkg::MODE_W-1:0]    mode_q;
  logic [clp_pkg::SOFT_W-1:0]    soft_q;

  logic [clp_pkg::SAMPLE_BITS-1:0] expected_samples[$];

  localparam longint ONE_Q30 = 64'sd1 <<< 30;

  function automatic longint round_shift(longint v, int n);
    if (n == 0) return v;
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint quintic_curve(longint s);
    longint p;
    if (s >= (64'sd5 <<< 28)) return ONE_Q30;
    if (s <= -(64'sd5 <<< 28)) return -ONE_Q30;
    p = s;
    for (int i = 0; i < 4; i++) p = round_shift(p * s, 30);
    return s - round_shift(64'sd87960930 * p, 30);
  endfunction

  function automatic longint atan_curve(longint s);
    longint angles[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    longint soft_lim, k, cx, cy, cz, xs, ys;
    soft_lim = (soft_q > 4096) ? 4096 : longint'(soft_q);
    k  = 6554 - ((2458 * soft_lim + 2048) >>> 12);
    cx = ONE_Q30;
    cy = round_shift(s * k, 12);
    cz = 0;
    for (int i = 0; i < ((clp_pkg::ATAN_STEPS > 24) ? 24 : clp_pkg::ATAN_STEPS); i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy > 0) begin
        cx += ys; cy -= xs; cz += angles[i];
      end else begin
        cx -= ys; cy += xs; cz -= angles[i];
      end
    end
    return cz;
  endfunction

  function automatic logic [clp_pkg::SAMPLE_BITS-1:0] clip_sample(
      logic [clp_pkg::SAMPLE_BITS-1:0] raw);
    longint x, g, s, y, r;
    if (bypass_q) return raw;
    x = longint'($signed(raw));
    g = round_shift(x * longint'(gain_q), 12);
    s = round_shift(g * longint'(cinv_q), clp_pkg::FRAC - 14);
    case (mode_q)
      clp_pkg::MODE_HARD:
        y = (s > ONE_Q30) ? ONE_Q30 : ((s < -ONE_Q30) ? -ONE_Q30 : s);
      clp_pkg::MODE_QUINTIC: y = quintic_curve(s);
      clp_pkg::MODE_ATAN:    y = atan_curve(s);
      default:               y = 0;
    endcase
    r = round_shift(y * longint'(ceil_q), 42 - clp_pkg::FRAC);
    if (r > (64'sd1 <<< clp_pkg::FRAC) - 1) r = (64'sd1 <<< clp_pkg::FRAC) - 1;
    if (r < -(64'sd1 <<< clp_pkg::FRAC)) r = -(64'sd1 <<< clp_pkg::FRAC);
    return r[clp_pkg::SAMPLE_BITS-1:0];
  endfunction

  assign pending = expected_samples.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      bypass_q <= 1'b0;
      gain_q   <= 16'd4096;
      cinv_q   <= 24'd65536;
      ceil_q   <= 16'd4096;
      mode_q   <= clp_pkg::MODE_HARD;
      soft_q   <= '0;
      errors   <= 0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          clp_pkg::CFG_BYPASS:    bypass_q <= cfg_wdata[0];
          clp_pkg::CFG_BAND_GAIN: gain_q   <= cfg_wdata[clp_pkg::GAIN_W-1:0];
          clp_pkg::CFG_CEIL_INV:  cinv_q   <= cfg_wdata[clp_pkg::CINV_W-1:0];
          clp_pkg::CFG_CEILING:   ceil_q   <= cfg_wdata[clp_pkg::CEIL_W-1:0];
          clp_pkg::CFG_WAVE_MODE: mode_q   <= cfg_wdata[clp_pkg::MODE_W-1:0];
          clp_pkg::CFG_SOFTNESS:  soft_q   <= cfg_wdata[clp_pkg::SOFT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_samples.push_back(clip_sample(in_sample_in));
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: output beat %h with nothing expected", $time, out_sample_out);
          errors <= errors + 1;
        end else begin
          if (expected_samples[0] !== out_sample_out) begin
            $display("%0t: sample_out expected %h actual %h", $time,
                     expected_samples[0], out_sample_out);
            errors <= errors + 1;
          end
          void'(expected_samples.pop_front());
        end
      end
    end
  end
endmodule

>>> bench/audio_waveshaping_clipper_top_tb.sv
// ----------------------------------------------------------------------------
// audio_waveshaping_clipper_top_tb: stimulus for the waveshaping clipper
// Walks several register settings, sends directed and random samples with
// random gaps and output stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module audio_waveshaping_clipper_top_tb;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [clp_pkg::SAMPLE_BITS-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [clp_pkg::SAMPLE_BITS-1:0] out_sample_out;
  logic cfg_we = 1'b0;
  logic [clp_pkg::CFG_IDX_W-1:0] cfg_index = clp_pkg::CFG_BYPASS;
  logic [clp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int errors, pending, cycle_count;
  int idle_pct = 22;
  int hold_off = 0;

  audio_waveshaping_clipper_top u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample_in, .out_valid, .out_ready,
    .out_sample_out, .cfg_we, .cfg_index, .cfg_wdata
  );

  clipper_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample_in, .out_valid, .out_ready,
    .out_sample_out, .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off  <= hold_off - 1;
    end else out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // leaves cfg_we high; load_setting drops it after the last write
  task automatic write_reg(logic [clp_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[clp_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // returns at the accepting edge with valid still high
  task automatic send_sample(logic signed [clp_pkg::SAMPLE_BITS-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [clp_pkg::SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      1: return clp_pkg::SAMPLE_BITS'($signed($urandom_range(4096)) - 2048);
      default: return clp_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic load_setting(int unsigned bp, int unsigned gn, int unsigned ci,
                              int unsigned cl, int unsigned md, int unsigned sf);
    settle();
    write_reg(clp_pkg::CFG_BYPASS, bp);
    write_reg(clp_pkg::CFG_BAND_GAIN, gn);
    write_reg(clp_pkg::CFG_CEIL_INV, ci);
    write_reg(clp_pkg::CFG_CEILING, cl);
    write_reg(clp_pkg::CFG_WAVE_MODE, md);
    write_reg(clp_pkg::CFG_SOFTNESS, sf);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic signed [clp_pkg::SAMPLE_BITS-1:0] edge_vals[8] = '{24'sh7FFFFF, 24'sh800000,
      24'sh000000, 24'sh000001, 24'shFFFFFF, 24'sh400000, 24'shC00000, 24'sh555555};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: wave modes 0 to 3 at unity, then bypass, zero gain and ceilings, atan extremes
    for (int m = 0; m < 4; m++) begin
      load_setting(0, 4096, 65536, 4096, m, (m == 2) ? 2048 : 0);
      for (int i = 0; i < 5; i++) send_sample(edge_vals[i]);
    end
    load_setting(1, 4096, 65536, 4096, clp_pkg::MODE_HARD, 0);
    send_sample(24'sh123456);
    send_sample(24'sh800000);
    load_setting(0, 0, 0, 0, clp_pkg::MODE_QUINTIC, 8191);
    send_sample(24'sh7FFFFF);
    load_setting(0, 4096, 1, 65535, clp_pkg::MODE_ATAN, 4097);
    send_sample(24'sh400000);

    // random phases, including register extremes
    for (int ph = 0; ph < 16; ph++) begin
      int unsigned gn, ci, cl;
      gn = (ph == 1) ? 65535 : ((ph == 2) ? 0 : $urandom_range(1024, 16384));
      ci = (ph == 3) ? 24'hFFFFFF : ((ph == 4) ? 1 : $urandom_range(16384, 262144));
      cl = (ph == 5) ? 65535 : ((ph == 6) ? 1 : $urandom_range(1024, 8192));
      load_setting((ph == 7), gn, ci, cl, (ph == 8) ? 3 : $urandom_range(2),
                   (ph == 9) ? 8191 : $urandom_range(4096));
      idle_pct = (ph == 10) ? 0 : 22;
      if (ph == 11) begin
        hold_off <= 200;
        @(posedge clk);
      end
      for (int i = 0; i < 100; i++) send_sample(random_sample());
      if (ph == 12) settle();
    end

    idle_pct = 22;
    settle();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

>>> filelist.f
rtl/clp_pkg.sv
rtl/clp_front.sv
rtl/clp_shaper.sv
rtl/clp_back.sv
rtl/clp_outbuf.sv
rtl/audio_waveshaping_clipper_top.sv
bench/clipper_checker.sv
bench/audio_waveshaping_clipper_top_tb.sv
